>>> rtl/spinor_pkg.sv
// Shared constants, command codes and register layout of the SPI NOR command engine.
`default_nettype none

package spinor_pkg;

  // Array geometry
  localparam int unsigned ARRAY_BYTES = 65536;
  localparam int unsigned ADDR_W      = $clog2(ARRAY_BYTES);
  localparam int unsigned LEFT_W      = ADDR_W + 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ARRAY_BYTES - 1);

  // Erase span lengths in bytes
  localparam logic [LEFT_W-1:0] SPAN_4K   = LEFT_W'(4096);
  localparam logic [LEFT_W-1:0] SPAN_32K  = LEFT_W'(32768);
  localparam logic [LEFT_W-1:0] SPAN_64K  = LEFT_W'(65536);
  localparam logic [LEFT_W-1:0] SPAN_BULK = LEFT_W'(ARRAY_BYTES);

  // Command codes
  typedef enum logic [4:0] {
    CMD_NOP     = 5'd0,
    CMD_READ    = 5'd1,
    CMD_RDID    = 5'd2,
    CMD_RDSR    = 5'd3,
    CMD_RDFSR   = 5'd4,
    CMD_RDVCFG  = 5'd5,
    CMD_RDEVCFG = 5'd6,
    CMD_WREN    = 5'd7,
    CMD_WRDI    = 5'd8,
    CMD_WRVCFG  = 5'd9,
    CMD_WREVCFG = 5'd10,
    CMD_WRSR    = 5'd11,
    CMD_PROGRAM = 5'd12,
    CMD_ERASE4K = 5'd13,
    CMD_ERASE32K = 5'd14,
    CMD_ERASE64K = 5'd15,
    CMD_BULK    = 5'd16,
    CMD_CLRFSR  = 5'd17
  } cmd_t;

  // Configuration register indexes
  typedef enum logic {
    REG_ID_BYTES  = 1'b0,
    REG_ID_LENGTH = 1'b1
  } reg_idx_t;

  // Status and flag status bits
  localparam logic [7:0] SR_WEL          = 8'h02;
  localparam logic [7:0] SR_WIP          = 8'h01;
  localparam logic [7:0] FLAG_READY      = 8'h80;
  localparam logic [7:0] FLAG_ERASE_FAIL = 8'h20;
  localparam logic [7:0] FLAG_PROG_FAIL  = 8'h10;

  // Reset values
  localparam logic [7:0]  ERASED_BYTE    = 8'hFF;
  localparam logic [7:0]  SR_RESET       = 8'h00;
  localparam logic [7:0]  FSR_RESET      = FLAG_READY;
  localparam logic [7:0]  VCFG_RESET     = 8'hFB;
  localparam logic [7:0]  EVCFG_RESET    = 8'hFF;
  localparam logic [31:0] ID_BYTES_RESET = 32'd1686304;
  localparam logic [2:0]  ID_LEN_RESET   = 3'd4;
  localparam logic [2:0]  ID_LEN_MAX     = 3'd4;

endpackage

`default_nettype wire

>>> rtl/spi_nor_flash_command_engine.sv
// SPI NOR flash command engine: byte array in a synchronous RAM, command pipeline and erase walker.
//
// Each accepted command yields exactly one response (read_data, data_valid). Reads,
// byte programs and register commands go through a two-stage flow around the array
// RAM (address in, registered read data, write-back of the ANDed byte), so they
// sustain one command per cycle as long as responses are taken (rsp_ready); the request
// is registered in stage 1 and its response in rsp_valid/read_data. A program followed
// by an access to the same byte is forwarded. Erase commands with WEL set run on a walker
// that writes one byte of 0xFF per cycle; the next request is taken once it has covered
// N bytes, N being 4096, 32768 or 65536 (sector erases are clipped at the array end)
// or 65536 for bulk erase. After reset the same walker runs a clearing pass over all
// 65536 bytes with cmd_ready low; configuration writes over APB are taken at any time.
`default_nettype none

module spi_nor_flash_command_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  // command request channel
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire logic [4:0]  command,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_fragment,
  // response channel
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [7:0]       read_data,
  output logic             data_valid,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_WALK
  } state_t;

  state_t state;

  // configuration registers
  logic [31:0] id_bytes;
  logic [2:0]  id_length;

  // device registers
  logic [7:0] dev_status;
  logic [7:0] fsr;
  logic [7:0] vcfg;
  logic [7:0] evcfg;

  // stage 1 request
  logic                      s1_valid;
  logic [4:0]                s1_cmd;
  logic [spinor_pkg::ADDR_W-1:0] s1_addr;
  logic [7:0]                s1_data;
  logic                      s1_last;

  // erase and clearing walker
  logic [spinor_pkg::ADDR_W-1:0] walk_addr;
  logic [spinor_pkg::LEFT_W-1:0] walk_left;
  logic                          walk_done;

  // array RAM ports
  logic [7:0]                    mem [spinor_pkg::ARRAY_BYTES];
  logic                          mem_we;
  logic [spinor_pkg::ADDR_W-1:0] mem_wa;
  logic [7:0]                    mem_wd;
  logic [spinor_pkg::ADDR_W-1:0] mem_ra;
  logic [7:0]                    mem_rd;
  logic                          fwd_hit;
  logic [7:0]                    fwd_data;
  logic [7:0]                    mem_byte;

  // stage 1 decode
  logic        cmd_accept;
  logic        s1_fire;
  logic        s1_erase;
  logic        wel;
  logic [2:0]  id_len_eff;
  logic [7:0]  rd_byte;
  logic        rd_valid;
  logic        prog_we;
  logic [7:0]  status_next;
  logic [7:0]  fsr_next;
  logic [7:0]  vcfg_next;
  logic [7:0]  evcfg_next;
  logic        walk_start;
  logic [spinor_pkg::ADDR_W-1:0] walk_addr_next;
  logic [spinor_pkg::LEFT_W-1:0] walk_left_next;
  logic        cfg_write;

  // handshakes
  assign s1_fire    = s1_valid && (!rsp_valid || rsp_ready);
  assign s1_erase   = (s1_cmd == spinor_pkg::CMD_ERASE4K) ||
                      (s1_cmd == spinor_pkg::CMD_ERASE32K) ||
                      (s1_cmd == spinor_pkg::CMD_ERASE64K) ||
                      (s1_cmd == spinor_pkg::CMD_BULK);
  assign cmd_ready  = (state == ST_RUN) && (!s1_valid || (s1_fire && !s1_erase));
  assign cmd_accept = cmd_valid && cmd_ready;
  assign wel        = (dev_status & spinor_pkg::SR_WEL) != 8'h00;
  assign walk_done  = (walk_left == spinor_pkg::LEFT_W'(1)) ||
                      (walk_addr == spinor_pkg::LAST_ADDR);

  // pick the freshest copy of the addressed byte
  assign mem_byte = fwd_hit ? fwd_data : mem_rd;

  // clamp the ID length
  assign id_len_eff = (id_length > spinor_pkg::ID_LEN_MAX) ? spinor_pkg::ID_LEN_MAX
                                                            : id_length;

  // execute the stage 1 command
  always_comb begin
    rd_byte        = 8'h00;
    rd_valid       = 1'b0;
    prog_we        = 1'b0;
    status_next    = dev_status;
    fsr_next       = fsr;
    vcfg_next      = vcfg;
    evcfg_next     = evcfg;
    walk_start     = 1'b0;
    walk_addr_next = s1_addr;
    walk_left_next = spinor_pkg::SPAN_4K;
    unique case (spinor_pkg::cmd_t'(s1_cmd))
      spinor_pkg::CMD_READ: begin
        rd_byte  = mem_byte;
        rd_valid = 1'b1;
      end
      spinor_pkg::CMD_RDID: begin
        if ({14'd0, s1_addr} < {14'd0, 13'd0, id_len_eff}) begin
          rd_byte  = id_bytes[{s1_addr[1:0], 3'b000} +: 8];
          rd_valid = 1'b1;
        end
      end
      spinor_pkg::CMD_RDSR: begin
        rd_byte  = dev_status;
        rd_valid = 1'b1;
      end
      spinor_pkg::CMD_RDFSR: begin
        rd_byte  = fsr;
        rd_valid = 1'b1;
      end
      spinor_pkg::CMD_RDVCFG: begin
        rd_byte  = vcfg;
        rd_valid = 1'b1;
      end
      spinor_pkg::CMD_RDEVCFG: begin
        rd_byte  = evcfg;
        rd_valid = 1'b1;
      end
      spinor_pkg::CMD_WREN:    status_next = dev_status | spinor_pkg::SR_WEL;
      spinor_pkg::CMD_WRDI:    status_next = dev_status & ~spinor_pkg::SR_WEL;
      spinor_pkg::CMD_WRVCFG:  vcfg_next = s1_data;
      spinor_pkg::CMD_WREVCFG: evcfg_next = s1_data;
      spinor_pkg::CMD_WRSR: begin
        if (wel) begin
          status_next = s1_data & ~(spinor_pkg::SR_WEL | spinor_pkg::SR_WIP);
        end
      end
      spinor_pkg::CMD_PROGRAM: begin
        if (!wel) begin
          fsr_next = fsr | spinor_pkg::FLAG_PROG_FAIL;
        end else begin
          prog_we = 1'b1;
          if (s1_last) begin
            status_next = dev_status & ~spinor_pkg::SR_WEL;
          end
        end
      end
      spinor_pkg::CMD_ERASE4K, spinor_pkg::CMD_ERASE32K,
      spinor_pkg::CMD_ERASE64K, spinor_pkg::CMD_BULK: begin
        if (!wel) begin
          fsr_next = fsr | spinor_pkg::FLAG_ERASE_FAIL;
        end else begin
          walk_start  = 1'b1;
          status_next = dev_status & ~spinor_pkg::SR_WEL;
          priority case (spinor_pkg::cmd_t'(s1_cmd))
            spinor_pkg::CMD_ERASE4K:  walk_left_next = spinor_pkg::SPAN_4K;
            spinor_pkg::CMD_ERASE32K: walk_left_next = spinor_pkg::SPAN_32K;
            spinor_pkg::CMD_ERASE64K: walk_left_next = spinor_pkg::SPAN_64K;
            default: begin
              walk_left_next = spinor_pkg::SPAN_BULK;
              walk_addr_next = '0;
            end
          endcase
        end
      end
      spinor_pkg::CMD_CLRFSR: fsr_next = spinor_pkg::FLAG_READY;
      default: ;
    endcase
  end

  // array write and read addresses
  always_comb begin
    if (state != ST_RUN) begin
      mem_we = 1'b1;
      mem_wa = walk_addr;
      mem_wd = spinor_pkg::ERASED_BYTE;
    end else begin
      mem_we = s1_fire && prog_we;
      mem_wa = s1_addr;
      mem_wd = mem_byte & s1_data;
    end
  end

  assign mem_ra = cmd_accept ? address : s1_addr;

  // array RAM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd <= mem[mem_ra];
  end

  // note a write that the read in the same cycle missed
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= mem_we && (mem_wa == mem_ra);
    end
    fwd_data <= mem_wd;
  end

  // hold the stage 1 payload
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      s1_cmd  <= command;
      s1_addr <= address;
      s1_data <= data_byte;
      s1_last <= last_fragment;
    end
  end

  // state, walker, device registers and response
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      walk_addr  <= '0;
      walk_left  <= spinor_pkg::SPAN_BULK;
      s1_valid   <= 1'b0;
      rsp_valid  <= 1'b0;
      read_data  <= 8'h00;
      data_valid <= 1'b0;
      dev_status <= spinor_pkg::SR_RESET;
      fsr        <= spinor_pkg::FSR_RESET;
      vcfg       <= spinor_pkg::VCFG_RESET;
      evcfg      <= spinor_pkg::EVCFG_RESET;
    end else begin
      unique case (state)
        ST_CLEAR, ST_WALK: begin
          walk_addr <= walk_addr + spinor_pkg::ADDR_W'(1);
          walk_left <= walk_left - spinor_pkg::LEFT_W'(1);
          if (walk_done) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (s1_fire && walk_start) begin
            state     <= ST_WALK;
            walk_addr <= walk_addr_next;
            walk_left <= walk_left_next;
          end
        end
        default: state <= ST_CLEAR;
      endcase

      // advance stage 1
      if (cmd_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      // commit stage 1 effects
      if (s1_fire) begin
        dev_status <= status_next;
        fsr        <= fsr_next;
        vcfg       <= vcfg_next;
        evcfg      <= evcfg_next;
      end

      // load or drop the response
      if (s1_fire) begin
        rsp_valid  <= 1'b1;
        read_data  <= rd_byte;
        data_valid <= rd_valid;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // configuration writes
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_bytes  <= spinor_pkg::ID_BYTES_RESET;
      id_length <= spinor_pkg::ID_LEN_RESET;
    end else if (cfg_write) begin
      unique case (spinor_pkg::reg_idx_t'(paddr[2]))
        spinor_pkg::REG_ID_BYTES:  id_bytes  <= pwdata;
        spinor_pkg::REG_ID_LENGTH: id_length <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    unique case (spinor_pkg::reg_idx_t'(paddr[2]))
      spinor_pkg::REG_ID_BYTES:  prdata = id_bytes;
      spinor_pkg::REG_ID_LENGTH: prdata = {29'd0, id_length};
      default:                   prdata = 32'd0;
    endcase
  end

`ifndef SYNTH
  // an enabled erase hands off to the walker
  a_erase_walks: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && walk_start) |=> (state == ST_WALK))
    else $error("erase did not start the walker");

  // no command sits in stage 1 while the walker owns the array
  a_walk_exclusive: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> !s1_valid)
    else $error("command in flight during erase or clearing pass");

  // forwarding only follows a real array write
  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> $past(mem_we))
    else $error("forwarding without a preceding write");
`endif

endmodule

`default_nettype wire
